// ===== hdl/cbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Types, constants and layout functions that the mapper and its window RAM share.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int SUBSLOT_COUNT_DEF = 4;
	localparam int WINDOW_COUNT      = 8;
	localparam int WINDOWS_PER_ROW   = 2;
	localparam int ROWS_PER_SUBSLOT  = WINDOW_COUNT / WINDOWS_PER_ROW;
	localparam int BANK_W            = 9;
	localparam int LOW_W             = 13;
	localparam int OFFSET_W          = BANK_W + LOW_W;
	localparam int TYPE_W            = 3;
	localparam int CFG_INDEX_W       = 2;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef enum logic [TYPE_W-1:0] {
		MT_OFF       = 3'd0,
		MT_RAM       = 3'd1,
		MT_LINEAR    = 3'd2,
		MT_MIRROR32K = 3'd3,
		MT_KONAMI    = 3'd4,
		MT_KONAMI_Z  = 3'd5,
		MT_ASCII8    = 3'd6,
		MT_ASCII16   = 3'd7
	} mapper_type_t;

	typedef enum logic [1:0] {
		REGION_NONE = 2'd0,
		REGION_ROM  = 2'd1,
		REGION_RAM  = 2'd2
	} region_t;

	typedef struct packed {
		logic [1:0]  subslot;
		logic        mode;
		logic [15:0] address;
		logic [7:0]  data;
	} request_t;

	typedef struct packed {
		logic                mapped;
		region_t             region;
		logic [OFFSET_W-1:0] offset;
		logic                bank_switched;
	} result_t;

	// one write into a window-pair row: mask bit 0 even window, bit 1 odd window
	typedef struct packed {
		logic              en;
		logic [1:0]        mask;
		logic [BANK_W-1:0] bank_even;
		logic [BANK_W-1:0] bank_odd;
	} win_write_t;

	typedef struct packed {
		logic       en;
		logic [1:0] subslot;
	} win_clear_t;

	function automatic logic window_live(mapper_type_t t, logic [2:0] w);
		logic live;
		case (t)
			MT_OFF:                              live = 1'b0;
			MT_MIRROR32K, MT_KONAMI, MT_KONAMI_Z: live = (w inside {[3'd2:3'd5]});
			default:                             live = 1'b1;
		endcase
		return live;
	endfunction

	function automatic logic [BANK_W-1:0] init_bank(mapper_type_t t, logic [2:0] w);
		logic [BANK_W-1:0] bank;
		case (t)
			MT_RAM, MT_LINEAR: bank = {{(BANK_W-3){1'b0}}, w};
			MT_MIRROR32K, MT_KONAMI, MT_KONAMI_Z:
				bank = (w inside {[3'd2:3'd5]}) ? {{(BANK_W-3){1'b0}}, w - 3'd2} : '0;
			MT_ASCII16:        bank = {{(BANK_W-1){1'b0}}, w[0]};
			default:           bank = '0;
		endcase
		return bank;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/cbm_window_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bank window RAM
// Window-pair rows with registered read, masked write and per-window
// written flags; a clear drops the flags of one subslot.
// ----------------------------------------------------------------------------
module cbm_window_ram import cbm_pkg::*; #(
	parameter int SUBSLOT_COUNT = SUBSLOT_COUNT_DEF,
	parameter int ROWS          = SUBSLOT_COUNT * ROWS_PER_SUBSLOT,
	parameter int ROW_W         = $clog2(ROWS)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire logic [ROW_W-1:0]   rd_row,
	input  wire logic [ROW_W-1:0]   wr_row,
	input  wire win_write_t         wr,
	input  wire win_clear_t         clr,
	output logic [BANK_W-1:0]       rd_even_q,
	output logic [BANK_W-1:0]       rd_odd_q,
	output logic [1:0]              rd_written_q
);

	logic [BANK_W-1:0] even_mem [ROWS];
	logic [BANK_W-1:0] odd_mem  [ROWS];
	logic [1:0]        written_q [ROWS];

	always_ff @(posedge clk) begin
		if (wr.en && wr.mask[0]) begin
			even_mem[wr_row] <= wr.bank_even;
		end
		if (wr.en && wr.mask[1]) begin
			odd_mem[wr_row] <= wr.bank_odd;
		end
		if (rd_en) begin
			rd_even_q <= even_mem[rd_row];
			rd_odd_q  <= odd_mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				written_q[r] <= 2'b00;
			end
			rd_written_q <= 2'b00;
		end else begin
			if (rd_en) begin
				rd_written_q <= written_q[rd_row];
			end
			for (int r = 0; r < ROWS; r++) begin
				if (clr.en && (r / ROWS_PER_SUBSLOT) == 32'(clr.subslot)) begin
					written_q[r] <= 2'b00;
				end else if (wr.en && 32'(wr_row) == r) begin
					written_q[r] <= written_q[r] | wr.mask;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cartridge_bank_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cartridge bank mapper
// Maps subslot bus requests to 8 KiB bank offsets for RAM, ROM and megaROM types.
// ----------------------------------------------------------------------------
// Usage:
//   request channel (request_valid/request_ready) carries subslot, mode, address
//   and data; result channel (result_valid/result_ready) carries mapped, region,
//   offset and bank_switched, exactly one result per request, in order.
//   cfg_we/cfg_index/cfg_data set the mapper type of a subslot; write them only
//   while no request is in flight. A type write re-initialises that subslot's
//   windows at once. Indexes at or above SUBSLOT_COUNT are ignored.
//   A request enters the lookup stage, then the result register. Throughput
//   is one request per cycle unless the receiver stalls: the window RAM is read
//   and a bank switch is written at acceptance, so the next request sees it.
//   When the receiver stalls, the result register holds and one more request
//   waits in the lookup stage; request_ready falls only when both are full.
//   Reset clears all types to off and all windows to their initial layout
//   immediately; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper import cbm_pkg::*; #(
	parameter int SUBSLOT_COUNT = SUBSLOT_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [TYPE_W-1:0]      cfg_data,
	input  wire logic                   request_valid,
	output logic                        request_ready,
	input  wire request_t               request,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output result_t                     result
);

	localparam int ROWS  = SUBSLOT_COUNT * ROWS_PER_SUBSLOT;
	localparam int ROW_W = $clog2(ROWS);
	localparam int SUB_W = (SUBSLOT_COUNT > 1) ? $clog2(SUBSLOT_COUNT) : 1;

	mapper_type_t types_q [SUBSLOT_COUNT];

	mapper_type_t req_type;
	logic [2:0]   req_win;
	logic         req_in_range;
	logic [1:0]   local_wr_row;
	logic [ROW_W-1:0] rd_row, wr_row;
	win_write_t   wr;
	win_clear_t   clr;
	logic         in_fire, out_take, s1_adv;

	logic         s1_valid_q;
	request_t     req_s1;
	mapper_type_t type_s1;
	logic         switched_s1;

	logic [BANK_W-1:0] rd_even_q, rd_odd_q;
	logic [1:0]        rd_written_q;

	logic [BANK_W-1:0] bank_s1;
	result_t           res_s1;
	result_t           result_q;
	logic              result_valid_q;

	assign out_take      = !result_valid_q || result_ready;
	assign s1_adv        = s1_valid_q && out_take;
	assign request_ready = !s1_valid_q || out_take;
	assign in_fire       = request_valid && request_ready;

	assign req_win      = request.address[15:13];
	assign req_in_range = 32'(request.subslot) < SUBSLOT_COUNT;
	assign req_type     = req_in_range ? types_q[request.subslot[SUB_W-1:0]] : MT_OFF;

	assign rd_row = req_in_range ?
		ROW_W'(32'(request.subslot) * ROWS_PER_SUBSLOT + 32'(req_win[2:1])) : '0;
	assign wr_row = req_in_range ?
		ROW_W'(32'(request.subslot) * ROWS_PER_SUBSLOT + 32'(local_wr_row)) : '0;

	// decode bank switches
	always_comb begin
		wr           = '0;
		local_wr_row = req_win[2:1];
		if (request.mode == MODE_WRITE) begin
			case (req_type)
				MT_KONAMI, MT_KONAMI_Z: begin
					if ((req_type == MT_KONAMI && req_win inside {[3'd2:3'd5]}) ||
					    req_win inside {[3'd4:3'd5]}) begin
						wr.en        = 1'b1;
						wr.mask      = req_win[0] ? 2'b10 : 2'b01;
						wr.bank_even = {1'b0, request.data};
						wr.bank_odd  = {1'b0, request.data};
					end
				end
				MT_ASCII8: begin
					if (req_win == 3'd3) begin
						local_wr_row = 2'd1 + {1'b0, request.address[12]};
						wr.en        = 1'b1;
						wr.mask      = request.address[11] ? 2'b10 : 2'b01;
						wr.bank_even = {1'b0, request.data};
						wr.bank_odd  = {1'b0, request.data};
					end
				end
				MT_ASCII16: begin
					if (req_win == 3'd3) begin
						local_wr_row = 2'd1 + {1'b0, request.address[12]};
						wr.en        = 1'b1;
						wr.mask      = 2'b11;
						wr.bank_even = {request.data, 1'b0};
						wr.bank_odd  = {request.data, 1'b1};
					end
				end
				default: ;
			endcase
		end
		wr.en = wr.en && in_fire;
	end

	assign clr.en      = cfg_we && (32'(cfg_index) < SUBSLOT_COUNT);
	assign clr.subslot = cfg_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SUBSLOT_COUNT; s++) begin
				types_q[s] <= MT_OFF;
			end
		end else if (clr.en) begin
			types_q[cfg_index[SUB_W-1:0]] <= mapper_type_t'(cfg_data);
		end
	end

	cbm_window_ram #(
		.SUBSLOT_COUNT (SUBSLOT_COUNT),
		.ROWS          (ROWS),
		.ROW_W         (ROW_W)
	) u_ram (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_en        (in_fire),
		.rd_row       (rd_row),
		.wr_row       (wr_row),
		.wr           (wr),
		.clr          (clr),
		.rd_even_q    (rd_even_q),
		.rd_odd_q     (rd_odd_q),
		.rd_written_q (rd_written_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1      <= request;
			type_s1     <= req_type;
			switched_s1 <= wr.en;
		end
	end

	// resolve window bank; unwritten windows take the type's initial layout
	always_comb begin
		logic [2:0] w;
		logic       odd;
		w       = req_s1.address[15:13];
		odd     = w[0];
		bank_s1 = rd_written_q[odd] ? (odd ? rd_odd_q : rd_even_q) : init_bank(type_s1, w);
		res_s1  = '0;
		if (req_s1.mode == MODE_READ) begin
			if (window_live(type_s1, w)) begin
				res_s1.mapped = 1'b1;
				res_s1.region = (type_s1 == MT_RAM) ? REGION_RAM : REGION_ROM;
				res_s1.offset = {bank_s1, req_s1.address[LOW_W-1:0]};
			end
		end else if (type_s1 == MT_RAM) begin
			res_s1.mapped = 1'b1;
			res_s1.region = REGION_RAM;
			res_s1.offset = {bank_s1, req_s1.address[LOW_W-1:0]};
		end else begin
			res_s1.bank_switched = switched_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_take) begin
			result_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_q <= res_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ===== hdl/cbm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cartridge bank mapper checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker import cbm_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_switch_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bank_switched |-> !result.mapped && result.offset == '0)
		else $error("bank switch reported as a mapped access");

	a_unmapped_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.mapped |-> result.region == REGION_NONE && result.offset == '0)
		else $error("unmapped result carries a region or offset");

	a_mapped_region: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.mapped |->
			(result.region == REGION_ROM || result.region == REGION_RAM))
		else $error("mapped result without a memory region");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);
`default_nettype wire

// ===== test/cartridge_bank_mapper_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper testbench
// Drives bus requests into the mapper under random idling on both channels,
// predicts each result from a local copy of the mapper types and bank windows,
// and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_tb;
	import cbm_pkg::*;

	localparam int IDLE_PCT       = 22;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SLOTS          = SUBSLOT_COUNT_DEF;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [TYPE_W-1:0]      cfg_data      = '0;
	logic                   request_valid = 1'b0;
	logic                   request_ready;
	request_t               request       = '0;
	logic                   result_valid;
	logic                   result_ready  = 1'b0;
	result_t                result;

	mapper_type_t      slot_type [SLOTS];
	logic [BANK_W-1:0] bank_of [SLOTS][WINDOW_COUNT];
	result_t           expected_results [$];
	result_t           want;
	bit                steady        = 1'b0;
	int                errors        = 0;
	int                n_requests    = 0;
	int                n_results     = 0;
	int                n_switches    = 0;
	int                n_type_writes = 0;
	int                quiet_cycles  = 0;

	cartridge_bank_mapper DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.request_valid(request_valid),
		.request_ready(request_ready),
		.request      (request),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void load_type(input int s, input mapper_type_t t);
		slot_type[s] = t;
		for (int w = 0; w < WINDOW_COUNT; w++) begin
			case (t)
				MT_RAM, MT_LINEAR:                    bank_of[s][w] = BANK_W'(w);
				MT_MIRROR32K, MT_KONAMI, MT_KONAMI_Z: bank_of[s][w] = (w >= 2 && w <= 5) ? BANK_W'(w - 2) : '0;
				MT_ASCII16:                           bank_of[s][w] = BANK_W'(w % 2);
				default:                              bank_of[s][w] = '0;
			endcase
		end
	endfunction

	function automatic result_t map_request(input request_t r);
		result_t      res;
		logic [1:0]   s;
		logic [2:0]   w;
		mapper_type_t t;
		logic         live;
		int           p;
		s = r.subslot;
		w = r.address[15:13];
		t = slot_type[s];
		res = '0;
		case (t)
			MT_OFF:                               live = 1'b0;
			MT_MIRROR32K, MT_KONAMI, MT_KONAMI_Z: live = (w >= 3'd2 && w <= 3'd5);
			default:                              live = 1'b1;
		endcase
		if (r.mode == MODE_READ) begin
			if (live) begin
				res.mapped = 1'b1;
				res.region = (t == MT_RAM) ? REGION_RAM : REGION_ROM;
				res.offset = {bank_of[s][w], r.address[LOW_W-1:0]};
			end
		end else begin
			case (t)
				MT_RAM: begin
					res.mapped = 1'b1;
					res.region = REGION_RAM;
					res.offset = {bank_of[s][w], r.address[LOW_W-1:0]};
				end
				MT_KONAMI, MT_KONAMI_Z: begin
					if ((w >= 3'd4 && w <= 3'd5) || (t == MT_KONAMI && w >= 3'd2 && w <= 3'd5)) begin
						bank_of[s][w] = {1'b0, r.data};
						res.bank_switched = 1'b1;
					end
				end
				MT_ASCII8: begin
					if (w == 3'd3) begin
						p = int'(r.address[12:11]);
						bank_of[s][2 + p] = {1'b0, r.data};
						res.bank_switched = 1'b1;
					end
				end
				MT_ASCII16: begin
					if (w == 3'd3) begin
						p = int'(r.address[12]);
						bank_of[s][2 + 2 * p] = {r.data, 1'b0};
						bank_of[s][3 + 2 * p] = {r.data, 1'b1};
						res.bank_switched = 1'b1;
					end
				end
				default: ;
			endcase
		end
		return res;
	endfunction

	function automatic request_t make_request(input logic [1:0] s, input logic m,
			input logic [15:0] a, input logic [7:0] d);
		request_t r;
		r.subslot = s;
		r.mode    = m;
		r.address = a;
		r.data    = d;
		return r;
	endfunction

	// bias towards the switch area and the paged windows
	function automatic request_t random_request();
		request_t r;
		int       pick;
		r.subslot = 2'($urandom_range(SLOTS - 1));
		r.mode    = ($urandom_range(99) < 45) ? MODE_WRITE : MODE_READ;
		r.data    = 8'($urandom);
		pick      = $urandom_range(99);
		if (pick < 40)
			r.address = 16'($urandom);
		else if (pick < 70)
			r.address = {3'd3, 13'($urandom)};
		else
			r.address = {3'($urandom_range(2, 5)), 13'($urandom)};
		return r;
	endfunction

	task automatic issue_request(input request_t r);
		result_t res;
		@(negedge clk);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				request_valid <= 1'b0;
				@(negedge clk);
			end
		end
		request_valid <= 1'b1;
		request       <= r;
		do @(posedge clk); while (!request_ready);
		res = map_request(r);
		expected_results.push_back(res);
		n_requests++;
		if (res.bank_switched)
			n_switches++;
	endtask

	task automatic settle();
		@(negedge clk);
		request_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_type(input int s, input mapper_type_t t);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INDEX_W'(s);
		cfg_data  <= t;
		@(negedge clk);
		cfg_we    <= 1'b0;
		load_type(s, t);
		n_type_writes++;
	endtask

	task automatic run_random(input int count);
		repeat (count) issue_request(random_request());
	endtask

	task automatic test_reset_state();
		issue_request(make_request(2'd0, MODE_READ, 16'h0000, 8'h00));
		issue_request(make_request(2'd3, MODE_WRITE, 16'hFFFF, 8'hFF));
		issue_request(make_request(2'd2, MODE_WRITE, 16'h7000, 8'h5A));
	endtask

	task automatic test_directed();
		settle();
		write_type(0, MT_RAM);
		write_type(1, MT_KONAMI);
		write_type(2, MT_ASCII8);
		write_type(3, MT_ASCII16);
		issue_request(make_request(2'd0, MODE_READ, 16'h0000, 8'h00));
		issue_request(make_request(2'd0, MODE_READ, 16'hFFFF, 8'h00));
		issue_request(make_request(2'd0, MODE_WRITE, 16'hA123, 8'hFF));
		issue_request(make_request(2'd1, MODE_READ, 16'h1000, 8'h00));
		issue_request(make_request(2'd1, MODE_READ, 16'h4000, 8'h00));
		issue_request(make_request(2'd1, MODE_WRITE, 16'h2000, 8'h00));
		issue_request(make_request(2'd1, MODE_WRITE, 16'h8000, 8'hFF));
		issue_request(make_request(2'd1, MODE_READ, 16'h9FFF, 8'h00));
		// same bank again still counts as a switch
		issue_request(make_request(2'd1, MODE_WRITE, 16'hBFFF, 8'h03));
		issue_request(make_request(2'd2, MODE_WRITE, 16'h6000, 8'h80));
		issue_request(make_request(2'd2, MODE_WRITE, 16'h7FFF, 8'h7F));
		issue_request(make_request(2'd2, MODE_READ, 16'h4000, 8'h00));
		issue_request(make_request(2'd2, MODE_READ, 16'hA000, 8'h00));
		issue_request(make_request(2'd2, MODE_WRITE, 16'h5FFF, 8'h11));
		issue_request(make_request(2'd3, MODE_WRITE, 16'h6000, 8'hFF));
		issue_request(make_request(2'd3, MODE_WRITE, 16'h7000, 8'h01));
		issue_request(make_request(2'd3, MODE_READ, 16'h6000, 8'h00));
		issue_request(make_request(2'd3, MODE_READ, 16'hE000, 8'h00));
		settle();
		write_type(0, MT_LINEAR);
		write_type(1, MT_MIRROR32K);
		write_type(2, MT_KONAMI_Z);
		write_type(3, MT_OFF);
		issue_request(make_request(2'd0, MODE_READ, 16'hE000, 8'h00));
		issue_request(make_request(2'd0, MODE_WRITE, 16'h6000, 8'hAA));
		issue_request(make_request(2'd1, MODE_READ, 16'h0000, 8'h00));
		issue_request(make_request(2'd1, MODE_READ, 16'hBFFF, 8'h00));
		issue_request(make_request(2'd2, MODE_WRITE, 16'h4000, 8'h05));
		issue_request(make_request(2'd2, MODE_WRITE, 16'hA000, 8'h05));
		issue_request(make_request(2'd3, MODE_READ, 16'h4000, 8'h00));
	endtask

	// every type lands on every subslot once
	task automatic test_type_sweep();
		for (int p = 0; p < 8; p++) begin
			settle();
			for (int s = 0; s < SLOTS; s++)
				write_type(s, mapper_type_t'((p + s) % 8));
			steady = (p == 3);
			run_random(100);
			steady = 1'b0;
		end
	endtask

	task automatic test_extreme_settings();
		settle();
		for (int s = 0; s < SLOTS; s++)
			write_type(s, MT_ASCII16);
		run_random(50);
		settle();
		for (int s = 0; s < SLOTS; s++)
			write_type(s, MT_OFF);
		run_random(50);
	endtask

	always @(negedge clk)
		result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.mapped !== want.mapped) begin
					$display("%0t: mapped expected %0d actual %0d", $time, want.mapped,
						result.mapped);
					errors++;
				end
				if (result.region !== want.region) begin
					$display("%0t: region expected %0d actual %0d", $time, want.region,
						result.region);
					errors++;
				end
				if (result.offset !== want.offset) begin
					$display("%0t: offset expected %h actual %h", $time, want.offset,
						result.offset);
					errors++;
				end
				if (result.bank_switched !== want.bank_switched) begin
					$display("%0t: bank_switched expected %0d actual %0d", $time,
						want.bank_switched, result.bank_switched);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((request_valid && request_ready) || (result_valid && result_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("cartridge_bank_mapper_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int s = 0; s < SLOTS; s++)
			load_type(s, MT_OFF);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_directed();
		test_type_sweep();
		test_extreme_settings();
		settle();
		$display("%0d requests and %0d results checked, %0d bank switches among them",
			n_requests, n_results, n_switches);
		$display("%0d mapper type writes, every type on every subslot", n_type_writes);
		if (errors == 0 && expected_results.size() == 0)
			$display("cartridge_bank_mapper_tb passed");
		else
			$display("cartridge_bank_mapper_tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/cbm_pkg.sv
hdl/cbm_window_ram.sv
hdl/cartridge_bank_mapper.sv
hdl/cbm_checker.sv
test/cartridge_bank_mapper_tb.sv
